// ----- src/dbeq_pkg.sv -----
package dbeq_pkg;

    // Default sizes of the button bank and the event queue.
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int FIFO_DEPTH_DEF  = 16;

    // Fixed field widths.
    localparam int PIN_W   = 8;
    localparam int COUNT_W = 8;
    localparam int BIDX_W  = 3;
    localparam int WAIT_W  = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
    localparam logic [WAIT_W-1:0]  WAIT_MAX  = 4'd15;

    // Input operation codes.
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Configuration port geometry and register indexes.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_STABLE_COUNT  = 1'b0;
    localparam logic REG_ACTIVE_LEVELS = 1'b1;

    localparam logic [COUNT_W-1:0] STABLE_COUNT_RST  = 8'd10;
    localparam logic [PIN_W-1:0]   ACTIVE_LEVELS_RST = 8'd0;

    // Requests from the sequencer to the event queue.
    typedef struct packed {
        logic              rd_en;
        logic              push;
        logic [BIDX_W-1:0] push_idx;
        logic              pop;
    } fifo_ctl_t;

    // Status returned by the event queue.
    typedef struct packed {
        logic              empty;
        logic [WAIT_W-1:0] waiting;
        logic [BIDX_W-1:0] rd_data;
    } fifo_stat_t;

endpackage

// ----- src/dbeq_in_if.sv -----
interface dbeq_in_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [dbeq_pkg::PIN_W-1:0] pin_levels;

    modport source (output valid, output func, output pin_levels, input ready);
    modport sink (input valid, input func, input pin_levels, output ready);
endinterface

// ----- src/dbeq_out_if.sv -----
interface dbeq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        event_valid;
    logic [dbeq_pkg::BIDX_W-1:0] button_index;
    logic [dbeq_pkg::WAIT_W-1:0] waiting;

    modport source (output valid, output event_valid, output button_index, output waiting,
                    input ready);
    modport sink (input valid, input event_valid, input button_index, input waiting,
                  output ready);
endinterface

// ----- src/dbeq_cfg.sv -----
module dbeq_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dbeq_pkg::PADDR_W-1:0]  paddr,
    input  logic [dbeq_pkg::PDATA_W-1:0]  pwdata,
    output logic [dbeq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [dbeq_pkg::COUNT_W-1:0]  stable_count,
    output logic [dbeq_pkg::PIN_W-1:0]    active_levels
);

    logic [dbeq_pkg::COUNT_W-1:0] stable_count_reg;
    logic [dbeq_pkg::PIN_W-1:0]   active_levels_reg;
    logic                         wr_xfer;
    logic                         reg_sel;

    // Registers sit on 4-byte boundaries; bit 2 picks the register.
    assign reg_sel = paddr[2];
    assign wr_xfer = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register writes at the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg  <= dbeq_pkg::STABLE_COUNT_RST;
            active_levels_reg <= dbeq_pkg::ACTIVE_LEVELS_RST;
        end
        else if (wr_xfer)
        begin
            unique case (reg_sel)
                dbeq_pkg::REG_STABLE_COUNT:
                    stable_count_reg <= pwdata[dbeq_pkg::COUNT_W-1:0];
                dbeq_pkg::REG_ACTIVE_LEVELS:
                    active_levels_reg <= pwdata[dbeq_pkg::PIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_sel)
            dbeq_pkg::REG_STABLE_COUNT:
                prdata = dbeq_pkg::PDATA_W'(stable_count_reg);
            dbeq_pkg::REG_ACTIVE_LEVELS:
                prdata = dbeq_pkg::PDATA_W'(active_levels_reg);
            default:
                prdata = '0;
        endcase
    end

    assign stable_count  = stable_count_reg;
    assign active_levels = active_levels_reg;

endmodule

// ----- src/dbeq_cnt_mem.sv -----
module dbeq_cnt_mem #(
    parameter int NUM_BUTTONS = dbeq_pkg::NUM_BUTTONS_DEF,
    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [dbeq_pkg::COUNT_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [dbeq_pkg::COUNT_W-1:0] wr_data
);

    logic [dbeq_pkg::COUNT_W-1:0] mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]       valid_reg;
    logic [dbeq_pkg::COUNT_W-1:0] rd_q_reg;
    logic                         rd_valid_reg;

    // Counter storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Entry valid bits stand in for clearing the counters at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A counter never written reads as zero.
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

// ----- src/dbeq_evt_fifo.sv -----
module dbeq_evt_fifo #(
    parameter int FIFO_DEPTH = dbeq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dbeq_pkg::fifo_ctl_t  ctl,
    output dbeq_pkg::fifo_stat_t stat
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = (PTR_W + 1 > dbeq_pkg::WAIT_W) ? PTR_W + 1 : dbeq_pkg::WAIT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [dbeq_pkg::BIDX_W-1:0] mem [FIFO_DEPTH];
    logic [dbeq_pkg::BIDX_W-1:0] rd_q_reg;
    logic [PTR_W-1:0]            wp_reg;
    logic [PTR_W-1:0]            rp_reg;
    logic [PTR_W-1:0]            wp_inc;
    logic [PTR_W-1:0]            rp_inc;
    logic                        full;
    logic                        do_push;
    logic [CNT_W-1:0]            fill;

    // Pointer advance with wrap at the queue depth.
    assign wp_inc  = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
    assign rp_inc  = (rp_reg == PTR_LAST) ? '0 : rp_reg + PTR_W'(1);
    assign full    = (wp_inc == rp_reg);
    assign do_push = ctl.push && !full;

    // Event storage: one write port, registered read at the read pointer.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= ctl.push_idx;
        end
        if (ctl.rd_en)
        begin
            rd_q_reg <= mem[rp_reg];
        end
    end

    // Pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_inc;
            end
            if (ctl.pop)
            begin
                rp_reg <= rp_inc;
            end
        end
    end

    // Fill level, saturated to the width of the waiting field.
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            fill = CNT_W'(wp_reg - rp_reg);
        end
        else
        begin
            fill = CNT_W'(FIFO_DEPTH) - CNT_W'(rp_reg) + CNT_W'(wp_reg);
        end
    end

    assign stat.empty   = (wp_reg == rp_reg);
    assign stat.waiting = (fill > CNT_W'(dbeq_pkg::WAIT_MAX)) ? dbeq_pkg::WAIT_MAX
                                                               : fill[dbeq_pkg::WAIT_W-1:0];
    assign stat.rd_data = rd_q_reg;

    // A push into a full queue is dropped and leaves the write pointer alone.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push && full && !ctl.pop) |=> $stable(wp_reg))
        else $error("write pointer moved on a push into a full queue");

    // The sequencer never pops an empty queue.
    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (wp_reg != rp_reg))
        else $error("pop issued on an empty queue");

    // Both pointers stay within the queue depth.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_LAST) && (rp_reg <= PTR_LAST))
        else $error("queue pointer beyond the last slot");

endmodule

// ----- src/debounced_button_event_queue_unit.sv -----
// Debounced button event queue. A tick transfer (func 0) walks the buttons one per
// clock through the counter memory, a read followed by a write-back; a pop transfer
// (func 1) takes the head of the event queue from the registered read of the event
// memory. One item is in work at a time; the next input transfer is taken as soon as
// the result of the previous one sits in the output register, even while that result
// still waits.
// Registers at byte 0 (stable_count) and byte 4 (active_levels) may only be written
// while no item is in work.
module debounced_button_event_queue_unit #(
    parameter int NUM_BUTTONS = dbeq_pkg::NUM_BUTTONS_DEF,
    parameter int FIFO_DEPTH  = dbeq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dbeq_pkg::PADDR_W-1:0] paddr,
    input  logic [dbeq_pkg::PDATA_W-1:0] pwdata,
    output logic [dbeq_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    dbeq_in_if.sink                      in_ch,
    dbeq_out_if.source                   out_ch
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUTTONS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_POP    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [IDX_W-1:0]             scan_idx_reg;
    logic [dbeq_pkg::PIN_W-1:0]   pins_reg;
    logic                         ev_valid_reg;
    logic [dbeq_pkg::BIDX_W-1:0]  ev_idx_reg;
    logic                         out_valid_reg;
    logic                         out_ev_reg;
    logic [dbeq_pkg::BIDX_W-1:0]  out_idx_reg;
    logic [dbeq_pkg::WAIT_W-1:0]  out_wait_reg;

    logic [dbeq_pkg::COUNT_W-1:0] stable_count;
    logic [dbeq_pkg::PIN_W-1:0]   active_levels;

    logic                         in_xfer;
    logic                         scan_last;
    logic                         out_load;
    logic                         cnt_rd_en;
    logic [IDX_W-1:0]             cnt_rd_addr;
    logic [dbeq_pkg::COUNT_W-1:0] cnt_rd_data;
    logic                         cnt_wr_en;
    logic [dbeq_pkg::COUNT_W-1:0] cnt_wr_data;
    logic                         hit;
    logic                         push;
    dbeq_pkg::fifo_ctl_t          fifo_ctl;
    dbeq_pkg::fifo_stat_t         fifo_stat;

    dbeq_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .stable_count  (stable_count),
        .active_levels (active_levels)
    );

    dbeq_cnt_mem #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data),
        .wr_en   (cnt_wr_en),
        .wr_addr (scan_idx_reg),
        .wr_data (cnt_wr_data)
    );

    dbeq_evt_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_evt_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fifo_ctl),
        .stat  (fifo_stat)
    );

    // Handshake.
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign scan_last   = (scan_idx_reg == IDX_LAST);
    assign out_load    = (state_reg == ST_FINISH) && (!out_valid_reg || out_ch.ready);

    // Counter reads: button 0 at the tick transfer, then one button ahead of the
    // write-back while the scan runs.
    assign cnt_rd_en   = (in_xfer && in_ch.func == dbeq_pkg::FUNC_TICK)
                      || (state_reg == ST_SCAN && !scan_last);
    assign cnt_rd_addr = in_xfer ? '0 : scan_idx_reg + IDX_W'(1);

    // Counter update for the button whose count has just been read.
    assign hit       = (pins_reg[scan_idx_reg] == active_levels[scan_idx_reg]);
    assign cnt_wr_en = (state_reg == ST_SCAN);

    always_comb
    begin
        cnt_wr_data = '0;
        push        = 1'b0;
        if (hit)
        begin
            if (cnt_rd_data != dbeq_pkg::COUNT_MAX)
            begin
                cnt_wr_data = cnt_rd_data + dbeq_pkg::COUNT_W'(1);
                push        = (cnt_wr_data == stable_count);
            end
            else
            begin
                cnt_wr_data = cnt_rd_data;
            end
        end
    end

    // Requests to the event queue.
    always_comb
    begin
        fifo_ctl.rd_en    = in_xfer && (in_ch.func == dbeq_pkg::FUNC_POP);
        fifo_ctl.push     = cnt_wr_en && push;
        fifo_ctl.push_idx = dbeq_pkg::BIDX_W'(scan_idx_reg);
        fifo_ctl.pop      = (state_reg == ST_POP) && !fifo_stat.empty;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (in_ch.func == dbeq_pkg::FUNC_POP) ? ST_POP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_POP:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                scan_idx_reg <= '0;
            end
            else if (state_reg == ST_SCAN && !scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // Item payload and the popped event.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pins_reg     <= in_ch.pin_levels;
            ev_valid_reg <= 1'b0;
            ev_idx_reg   <= '0;
        end
        else if (state_reg == ST_POP && !fifo_stat.empty)
        begin
            ev_valid_reg <= 1'b1;
            ev_idx_reg   <= fifo_stat.rd_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ev_reg   <= ev_valid_reg;
            out_idx_reg  <= ev_idx_reg;
            out_wait_reg <= fifo_stat.waiting;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.event_valid  = out_ev_reg;
    assign out_ch.button_index = out_idx_reg;
    assign out_ch.waiting      = out_wait_reg;

    // An input transfer always starts work on the next cycle.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_SCAN || state_reg == ST_POP))
        else $error("input transfer did not start a scan or a pop");

    // Counter writes and event pops never happen in the same cycle.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cnt_wr_en && fifo_ctl.pop))
        else $error("counter write-back overlaps a pop");

    // A waiting result stays valid and unchanged until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.event_valid)
            && $stable(out_ch.button_index) && $stable(out_ch.waiting)))
        else $error("waiting result changed before its transfer");

endmodule
